FILE: src/dpcc_pkg.sv
// Package for the distinct pixel code collector: shared widths, register
// indexes, the configuration bundle and the queue entry type.
// No dependencies.
package dpcc_pkg;

	localparam int CODE_W  = 24;
	localparam int COORD_W = 12;
	localparam int REG_W   = 13;
	localparam int MAXC_W  = 7;
	localparam int SLOT_W  = 6;
	localparam int CIDX_W  = 3;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;

	typedef enum logic [CIDX_W-1:0] {
		REG_RECT_X    = 3'd0,
		REG_RECT_Y    = 3'd1,
		REG_RECT_W    = 3'd2,
		REG_RECT_H    = 3'd3,
		REG_SURF_W    = 3'd4,
		REG_SURF_H    = 3'd5,
		REG_MAX_CODES = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [REG_W-1:0] rect_x;
		logic signed [REG_W-1:0] rect_y;
		logic [REG_W-1:0]        rect_w;
		logic [REG_W-1:0]        rect_h;
		logic [REG_W-1:0]        surf_w;
		logic [REG_W-1:0]        surf_h;
		logic [MAXC_W-1:0]       max_codes;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              cand;
		logic              last;
	} qitem_t;

	function automatic logic collect_enabled(cfg_t c);
		return (c.rect_w != '0) && (c.rect_h != '0) && (c.max_codes != '0);
	endfunction

endpackage

FILE: src/dpcc_front.sv
// Front end: accepts pixels, clips against the search rectangle and the
// surface, forms the code and pushes candidates and frame ends to the queue.
// Depends on dpcc_pkg.
module dpcc_front import dpcc_pkg::*; (
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [7:0]         blue_byte,
	input  logic [7:0]         green_byte,
	input  logic [7:0]         red_byte,
	input  logic               frame_last,
	input  logic               q_full,
	output logic               push,
	output qitem_t             push_item
);

	logic signed [REG_W+1:0] px, py, rx, ry, x1, y1, sw, sh;
	logic [CODE_W-1:0]       code;
	logic                    in_rect;

	assign px = $signed({3'b000, pixel_x});
	assign py = $signed({3'b000, pixel_y});
	assign rx = {{2{cfg.rect_x[REG_W-1]}}, cfg.rect_x};
	assign ry = {{2{cfg.rect_y[REG_W-1]}}, cfg.rect_y};
	assign x1 = rx + $signed({2'b00, cfg.rect_w});
	assign y1 = ry + $signed({2'b00, cfg.rect_h});
	assign sw = $signed({2'b00, cfg.surf_w});
	assign sh = $signed({2'b00, cfg.surf_h});

	// pixel coordinates are never negative, so the left clip at zero is implied
	assign in_rect = (px >= rx) && (px < x1) && (px < sw) &&
	                 (py >= ry) && (py < y1) && (py < sh);

	assign code = {blue_byte, green_byte, red_byte};

	assign push_item.code = code;
	assign push_item.cand = collect_enabled(cfg) && (code != '0) && in_rect;
	assign push_item.last = frame_last;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full && (push_item.cand || frame_last);

endmodule

FILE: src/dpcc_queue.sv
// Short FIFO between the front end and the lookup unit.
// Depends on dpcc_pkg.
module dpcc_queue import dpcc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output qitem_t head
);

	qitem_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full  = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: src/dpcc_back.sv
// Lookup unit: compares a queued code against all held codes, appends new
// ones, tracks the count and drives the registered result channel.
// Depends on dpcc_pkg.
module dpcc_back import dpcc_pkg::*; #(
	parameter int MAX_CODES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              empty,
	input  qitem_t            head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              new_code_valid,
	output logic [CODE_W-1:0] code_value,
	output logic [SLOT_W-1:0] slot_index,
	output logic              frame_done,
	output logic [MAXC_W-1:0] code_count,
	output logic              store_full
);

	localparam int CNT_W = $clog2(MAX_CODES + 1);
	localparam int IDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
	localparam int CMP_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_DECIDE = 2'b10
	} state_t;

	state_t               state_q;
	logic [CODE_W-1:0]    store_q [MAX_CODES];
	logic [MAX_CODES-1:0] match_s1;
	qitem_t               item_s1;
	logic [CNT_W-1:0]     count_q, count_nxt;
	logic [CMP_W-1:0]     limit, count_ext;
	logic [CNT_W+SLOT_W-1:0] slot_ext;
	logic [CNT_W+MAXC_W-1:0] cnt_ext;
	logic                 enabled, room, seen, added, emit, commit;

	logic                 out_valid_q, new_code_valid_q, frame_done_q, store_full_q;
	logic [CODE_W-1:0]    code_value_q;
	logic [SLOT_W-1:0]    slot_index_q;
	logic [MAXC_W-1:0]    code_count_q;

	assign pop = (state_q == S_IDLE) && !empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
			for (int j = 0; j < MAX_CODES; j++) begin
				match_s1[j] <= (store_q[j] == head.code) && (CNT_W'(j) < count_q);
			end
		end
	end

	always_comb begin
		enabled   = collect_enabled(cfg);
		limit     = (CMP_W'(cfg.max_codes) < CMP_W'(MAX_CODES)) ?
		            CMP_W'(cfg.max_codes) : CMP_W'(MAX_CODES);
		count_ext = CMP_W'(count_q);
		room      = count_ext < limit;
		seen      = |match_s1;
		added     = item_s1.cand && room && !seen;
		count_nxt = count_q + CNT_W'(added);
		emit      = added || item_s1.last;
		commit    = (state_q == S_DECIDE) && (!emit || !out_valid_q || out_ready);
		slot_ext  = {{SLOT_W{1'b0}}, count_q};
		cnt_ext   = {{MAXC_W{1'b0}}, count_nxt};
	end

	always_ff @(posedge clk) begin
		if (commit && added) begin
			store_q[count_q[IDX_W-1:0]] <= item_s1.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				count_q <= item_s1.last ? '0 : count_nxt;
			end
			if (commit && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emit) begin
			new_code_valid_q <= added;
			code_value_q     <= added ? item_s1.code : '0;
			slot_index_q     <= added ? slot_ext[SLOT_W-1:0] : '0;
			frame_done_q     <= item_s1.last;
			code_count_q     <= enabled ? cnt_ext[MAXC_W-1:0] : '0;
			store_full_q     <= enabled && (CMP_W'(count_nxt) >= limit);
		end
	end

	assign out_valid      = out_valid_q;
	assign new_code_valid = new_code_valid_q;
	assign code_value     = code_value_q;
	assign slot_index     = slot_index_q;
	assign frame_done     = frame_done_q;
	assign code_count     = code_count_q;
	assign store_full     = store_full_q;

endmodule

FILE: src/distinct_pixel_code_collector.sv
// Top level of the distinct pixel code collector: configuration registers,
// front end, queue and lookup unit. Depends on dpcc_pkg, dpcc_front,
// dpcc_queue and dpcc_back.
//
// A pixel outside the clipped rectangle, with a zero code, or arriving while
// collection is disabled is dropped by the front end in its accept cycle, one
// pixel per cycle while the queue is not full. A pixel that may add a code,
// and every frame's last pixel, goes through a four-entry queue to the lookup
// unit, which first compares it against all held codes in parallel, then
// commits the new code and loads the result register. This compare-then-commit
// loop takes no new pixel from the queue until the last one is committed; the
// queue absorbs short bursts. The result register frees the input side from
// output stalls until the queue fills. The code store needs no clearing after
// reset or at a frame end: only slots below the held count are ever compared.
module distinct_pixel_code_collector import dpcc_pkg::*; #(
	parameter int MAX_CODES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [7:0]         blue_byte,
	input  logic [7:0]         green_byte,
	input  logic [7:0]         red_byte,
	input  logic               frame_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               new_code_valid,
	output logic [CODE_W-1:0]  code_value,
	output logic [SLOT_W-1:0]  slot_index,
	output logic               frame_done,
	output logic [MAXC_W-1:0]  code_count,
	output logic               store_full
);

	cfg_t   cfg_q;
	logic   push, q_full, q_empty, pop;
	qitem_t push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rect_x    <= '0;
			cfg_q.rect_y    <= '0;
			cfg_q.rect_w    <= '0;
			cfg_q.rect_h    <= '0;
			cfg_q.surf_w    <= 13'd4096;
			cfg_q.surf_h    <= 13'd4096;
			cfg_q.max_codes <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RECT_X:    cfg_q.rect_x    <= $signed(cfg_data);
				REG_RECT_Y:    cfg_q.rect_y    <= $signed(cfg_data);
				REG_RECT_W:    cfg_q.rect_w    <= cfg_data;
				REG_RECT_H:    cfg_q.rect_h    <= cfg_data;
				REG_SURF_W:    cfg_q.surf_w    <= cfg_data;
				REG_SURF_H:    cfg_q.surf_h    <= cfg_data;
				REG_MAX_CODES: cfg_q.max_codes <= cfg_data[MAXC_W-1:0];
				default: ;
			endcase
		end
	end

	dpcc_front u_front (
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.blue_byte  (blue_byte),
		.green_byte (green_byte),
		.red_byte   (red_byte),
		.frame_last (frame_last),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	dpcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	dpcc_back #(
		.MAX_CODES (MAX_CODES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.empty          (q_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.new_code_valid (new_code_valid),
		.code_value     (code_value),
		.slot_index     (slot_index),
		.frame_done     (frame_done),
		.code_count     (code_count),
		.store_full     (store_full)
	);

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_code_valid || frame_done))
		else $error("result with neither a new code nor a frame end");

	a_new_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && new_code_valid) |-> (code_value != '0))
		else $error("zero code reported as new");

	a_no_code_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !new_code_valid) |-> (code_value == '0 && slot_index == '0))
		else $error("code payload without a new code");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("lookup took an entry from an empty queue");

endmodule
